[rtl/trcs_pkg.sv]
package trcs_pkg;

  // store geometry
  localparam int BANK_BYTES  = 256;
  localparam int NUM_BANKS   = 3;
  localparam int STORE_DEPTH = NUM_BANKS * BANK_BYTES;
  localparam int PHYS_W      = $clog2(STORE_DEPTH);
  localparam int ERR_ADDR_W  = 10;

  localparam logic [7:0]            ERASED         = 8'hFF;
  localparam logic [ERR_ADDR_W-1:0] ERR_ADDR_RESET = 10'd255;

  // command codes
  localparam logic [2:0] CMD_READ_B  = 3'd0;
  localparam logic [2:0] CMD_WRITE_B = 3'd1;
  localparam logic [2:0] CMD_READ_W  = 3'd2;
  localparam logic [2:0] CMD_WRITE_W = 3'd3;
  localparam logic [2:0] CMD_CLEAR   = 3'd4;
  localparam logic [2:0] CMD_RAW     = 3'd5;

  // fault codes
  localparam logic [2:0] ERR_OK     = 3'd0;
  localparam logic [2:0] ERR_REINIT = 3'd1;
  localparam logic [2:0] ERR_CORR   = 3'd2;
  localparam logic [2:0] ERR_SEVERE = 3'd3;

  // control word field codes
  localparam logic [1:0] MOP_NONE  = 2'd0;
  localparam logic [1:0] MOP_READ  = 2'd1;
  localparam logic [1:0] MOP_WRITE = 2'd2;

  localparam logic [1:0] BSEL_0   = 2'd0;
  localparam logic [1:0] BSEL_1   = 2'd1;
  localparam logic [1:0] BSEL_2   = 2'd2;
  localparam logic [1:0] BSEL_RAW = 2'd3;

  localparam logic [2:0] WS_LOV     = 3'd0;
  localparam logic [2:0] WS_HIV     = 3'd1;
  localparam logic [2:0] WS_VAL_LO  = 3'd2;
  localparam logic [2:0] WS_VAL_HI  = 3'd3;
  localparam logic [2:0] WS_DFLT_LO = 3'd4;
  localparam logic [2:0] WS_DFLT_HI = 3'd5;

  localparam logic [1:0] CAP_NONE = 2'd0;
  localparam logic [1:0] CAP_X    = 2'd1;
  localparam logic [1:0] CAP_Y    = 2'd2;

  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_VOTE_HI = 3'd1;
  localparam logic [2:0] ACT_VOTE_LO = 3'd2;
  localparam logic [2:0] ACT_RANGE_B = 3'd3;
  localparam logic [2:0] ACT_RANGE_W = 3'd4;
  localparam logic [2:0] ACT_FIN     = 3'd5;

  localparam logic [1:0] J_NONE   = 2'd0;
  localparam logic [1:0] J_ALWAYS = 2'd1;
  localparam logic [1:0] J_NOFIX  = 2'd2;
  localparam logic [1:0] J_KEEP   = 2'd3;

  // program entry points
  localparam int STEP_W = 6;
  localparam logic [STEP_W-1:0] ST_FIN   = 6'd0;
  localparam logic [STEP_W-1:0] ST_RDB   = 6'd1;
  localparam logic [STEP_W-1:0] ST_RDB_R = 6'd8;
  localparam logic [STEP_W-1:0] ST_RDW   = 6'd12;
  localparam logic [STEP_W-1:0] ST_RDW_L = 6'd19;
  localparam logic [STEP_W-1:0] ST_RDW_R = 6'd26;
  localparam logic [STEP_W-1:0] ST_WRB   = 6'd33;
  localparam logic [STEP_W-1:0] ST_WRW   = 6'd36;
  localparam logic [STEP_W-1:0] ST_RAW   = 6'd42;

  typedef struct packed {
    logic [1:0]        mop;
    logic [1:0]        bsel;
    logic              hi;
    logic [2:0]        wsel;
    logic [1:0]        cap;
    logic [2:0]        act;
    logic [1:0]        jc;
    logic [STEP_W-1:0] tgt;
  } uword_t;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [PHYS_W-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

  typedef struct packed {
    logic [7:0] val;
    logic       fix;
    logic       sev;
    logic [2:0] code;
    logic [1:0] bank;
  } vote_t;

  function automatic uword_t mk(logic [1:0] mop, logic [1:0] bsel, logic hi,
                                logic [2:0] wsel, logic [1:0] cap, logic [2:0] act,
                                logic [1:0] jc, logic [STEP_W-1:0] tgt);
    uword_t w;
    w.mop  = mop;
    w.bsel = bsel;
    w.hi   = hi;
    w.wsel = wsel;
    w.cap  = cap;
    w.act  = act;
    w.jc   = jc;
    w.tgt  = tgt;
    return w;
  endfunction

  // microprogram
  function automatic uword_t ucode(logic [STEP_W-1:0] s);
    uword_t w;
    unique case (s)
      // bounded byte read
      6'd1:  w = mk(MOP_READ,  BSEL_0, 1'b0, WS_LOV, CAP_NONE, ACT_NONE, J_NONE, ST_FIN);
      6'd2:  w = mk(MOP_READ,  BSEL_1, 1'b0, WS_LOV, CAP_X, ACT_NONE, J_NONE, ST_FIN);
      6'd3:  w = mk(MOP_READ,  BSEL_2, 1'b0, WS_LOV, CAP_Y, ACT_NONE, J_NONE, ST_FIN);
      6'd4:  w = mk(MOP_NONE,  BSEL_0, 1'b0, WS_LOV, CAP_NONE, ACT_VOTE_LO, J_NOFIX,
                    ST_RDB_R);
      6'd5:  w = mk(MOP_WRITE, BSEL_0, 1'b0, WS_LOV, CAP_NONE, ACT_NONE, J_NONE, ST_FIN);
      6'd6:  w = mk(MOP_WRITE, BSEL_1, 1'b0, WS_LOV, CAP_NONE, ACT_NONE, J_NONE, ST_FIN);
      6'd7:  w = mk(MOP_WRITE, BSEL_2, 1'b0, WS_LOV, CAP_NONE, ACT_NONE, J_NONE, ST_FIN);
      6'd8:  w = mk(MOP_NONE,  BSEL_0, 1'b0, WS_LOV, CAP_NONE, ACT_RANGE_B, J_KEEP,
                    ST_FIN);
      6'd9:  w = mk(MOP_WRITE, BSEL_0, 1'b0, WS_DFLT_LO, CAP_NONE, ACT_NONE, J_NONE,
                    ST_FIN);
      6'd10: w = mk(MOP_WRITE, BSEL_1, 1'b0, WS_DFLT_LO, CAP_NONE, ACT_NONE, J_NONE,
                    ST_FIN);
      6'd11: w = mk(MOP_WRITE, BSEL_2, 1'b0, WS_DFLT_LO, CAP_NONE, ACT_NONE, J_ALWAYS,
                    ST_FIN);
      // bounded word read, high byte first
      6'd12: w = mk(MOP_READ,  BSEL_0, 1'b1, WS_HIV, CAP_NONE, ACT_NONE, J_NONE, ST_FIN);
      6'd13: w = mk(MOP_READ,  BSEL_1, 1'b1, WS_HIV, CAP_X, ACT_NONE, J_NONE, ST_FIN);
      6'd14: w = mk(MOP_READ,  BSEL_2, 1'b1, WS_HIV, CAP_Y, ACT_NONE, J_NONE, ST_FIN);
      6'd15: w = mk(MOP_NONE,  BSEL_0, 1'b1, WS_HIV, CAP_NONE, ACT_VOTE_HI, J_NOFIX,
                    ST_RDW_L);
      6'd16: w = mk(MOP_WRITE, BSEL_0, 1'b1, WS_HIV, CAP_NONE, ACT_NONE, J_NONE, ST_FIN);
      6'd17: w = mk(MOP_WRITE, BSEL_1, 1'b1, WS_HIV, CAP_NONE, ACT_NONE, J_NONE, ST_FIN);
      6'd18: w = mk(MOP_WRITE, BSEL_2, 1'b1, WS_HIV, CAP_NONE, ACT_NONE, J_NONE, ST_FIN);
      6'd19: w = mk(MOP_READ,  BSEL_0, 1'b0, WS_LOV, CAP_NONE, ACT_NONE, J_NONE, ST_FIN);
      6'd20: w = mk(MOP_READ,  BSEL_1, 1'b0, WS_LOV, CAP_X, ACT_NONE, J_NONE, ST_FIN);
      6'd21: w = mk(MOP_READ,  BSEL_2, 1'b0, WS_LOV, CAP_Y, ACT_NONE, J_NONE, ST_FIN);
      6'd22: w = mk(MOP_NONE,  BSEL_0, 1'b0, WS_LOV, CAP_NONE, ACT_VOTE_LO, J_NOFIX,
                    ST_RDW_R);
      6'd23: w = mk(MOP_WRITE, BSEL_0, 1'b0, WS_LOV, CAP_NONE, ACT_NONE, J_NONE, ST_FIN);
      6'd24: w = mk(MOP_WRITE, BSEL_1, 1'b0, WS_LOV, CAP_NONE, ACT_NONE, J_NONE, ST_FIN);
      6'd25: w = mk(MOP_WRITE, BSEL_2, 1'b0, WS_LOV, CAP_NONE, ACT_NONE, J_NONE, ST_FIN);
      6'd26: w = mk(MOP_NONE,  BSEL_0, 1'b0, WS_LOV, CAP_NONE, ACT_RANGE_W, J_KEEP,
                    ST_FIN);
      6'd27: w = mk(MOP_WRITE, BSEL_0, 1'b1, WS_DFLT_HI, CAP_NONE, ACT_NONE, J_NONE,
                    ST_FIN);
      6'd28: w = mk(MOP_WRITE, BSEL_1, 1'b1, WS_DFLT_HI, CAP_NONE, ACT_NONE, J_NONE,
                    ST_FIN);
      6'd29: w = mk(MOP_WRITE, BSEL_2, 1'b1, WS_DFLT_HI, CAP_NONE, ACT_NONE, J_NONE,
                    ST_FIN);
      6'd30: w = mk(MOP_WRITE, BSEL_0, 1'b0, WS_DFLT_LO, CAP_NONE, ACT_NONE, J_NONE,
                    ST_FIN);
      6'd31: w = mk(MOP_WRITE, BSEL_1, 1'b0, WS_DFLT_LO, CAP_NONE, ACT_NONE, J_NONE,
                    ST_FIN);
      6'd32: w = mk(MOP_WRITE, BSEL_2, 1'b0, WS_DFLT_LO, CAP_NONE, ACT_NONE, J_ALWAYS,
                    ST_FIN);
      // byte write
      6'd33: w = mk(MOP_WRITE, BSEL_0, 1'b0, WS_VAL_LO, CAP_NONE, ACT_NONE, J_NONE,
                    ST_FIN);
      6'd34: w = mk(MOP_WRITE, BSEL_1, 1'b0, WS_VAL_LO, CAP_NONE, ACT_NONE, J_NONE,
                    ST_FIN);
      6'd35: w = mk(MOP_WRITE, BSEL_2, 1'b0, WS_VAL_LO, CAP_NONE, ACT_NONE, J_ALWAYS,
                    ST_FIN);
      // word write
      6'd36: w = mk(MOP_WRITE, BSEL_0, 1'b1, WS_VAL_HI, CAP_NONE, ACT_NONE, J_NONE,
                    ST_FIN);
      6'd37: w = mk(MOP_WRITE, BSEL_1, 1'b1, WS_VAL_HI, CAP_NONE, ACT_NONE, J_NONE,
                    ST_FIN);
      6'd38: w = mk(MOP_WRITE, BSEL_2, 1'b1, WS_VAL_HI, CAP_NONE, ACT_NONE, J_NONE,
                    ST_FIN);
      6'd39: w = mk(MOP_WRITE, BSEL_0, 1'b0, WS_VAL_LO, CAP_NONE, ACT_NONE, J_NONE,
                    ST_FIN);
      6'd40: w = mk(MOP_WRITE, BSEL_1, 1'b0, WS_VAL_LO, CAP_NONE, ACT_NONE, J_NONE,
                    ST_FIN);
      6'd41: w = mk(MOP_WRITE, BSEL_2, 1'b0, WS_VAL_LO, CAP_NONE, ACT_NONE, J_ALWAYS,
                    ST_FIN);
      // raw single-bank write
      6'd42: w = mk(MOP_WRITE, BSEL_RAW, 1'b0, WS_VAL_LO, CAP_NONE, ACT_NONE, J_ALWAYS,
                    ST_FIN);
      // finish step and unused codes
      default: w = mk(MOP_NONE, BSEL_0, 1'b0, WS_LOV, CAP_NONE, ACT_FIN, J_NONE, ST_FIN);
    endcase
    return w;
  endfunction

  // dispatch from command code
  function automatic logic [STEP_W-1:0] entry(logic [2:0] cmd);
    logic [STEP_W-1:0] s;
    unique case (cmd)
      CMD_READ_B:  s = ST_RDB;
      CMD_WRITE_B: s = ST_WRB;
      CMD_READ_W:  s = ST_RDW;
      CMD_WRITE_W: s = ST_WRW;
      CMD_RAW:     s = ST_RAW;
      default:     s = ST_FIN;
    endcase
    return s;
  endfunction

  // physical address of a byte in one bank
  function automatic logic [PHYS_W-1:0] phys_of(logic [1:0] bank, logic [7:0] la);
    int p;
    p = int'(bank) * BANK_BYTES + int'(la);
    return p[PHYS_W-1:0];
  endfunction

  // three-copy vote
  function automatic vote_t vote(logic [7:0] x, logic [7:0] y, logic [7:0] z,
                                 logic [7:0] d);
    vote_t r;
    r.val  = x;
    r.fix  = 1'b1;
    r.sev  = 1'b0;
    r.code = ERR_OK;
    r.bank = BSEL_0;
    priority if (x == y && y == z) begin
      r.fix = 1'b0;
    end else if (y == ERASED && z == ERASED) begin
      // erased copies: fill from bank 0, no fault
    end else if (x == y) begin
      r.code = ERR_CORR;
      r.bank = BSEL_2;
    end else if (x == z) begin
      r.code = ERR_CORR;
      r.bank = BSEL_1;
    end else if (y == z) begin
      r.val  = y;
      r.code = ERR_CORR;
    end else begin
      r.val  = d;
      r.fix  = 1'b0;
      r.sev  = 1'b1;
      r.code = ERR_SEVERE;
    end
    return r;
  endfunction

endpackage

[rtl/trcs_store.sv]
module trcs_store
  import trcs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mem_req_t req,
  output logic [7:0] rdata,
  output logic     busy
);

  logic [7:0]        mem [STORE_DEPTH];
  logic [7:0]        rdata_r;
  logic              busy_r, busy_nxt;
  logic [PHYS_W-1:0] clr_r, clr_nxt;

  // erase sweep after reset
  always_comb begin
    busy_nxt = busy_r;
    clr_nxt  = clr_r;
    if (busy_r) begin
      clr_nxt = clr_r + 1'b1;
      if (clr_r == PHYS_W'(STORE_DEPTH - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      clr_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      clr_r  <= clr_nxt;
    end
  end

  // single port: one access per cycle, registered read
  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_r] <= ERASED;
    end else if (req.en && req.we) begin
      mem[req.addr] <= req.wdata;
    end else if (req.en) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata = rdata_r;
  assign busy  = busy_r;

endmodule

[rtl/triple_redundant_config_store.sv]
// Triple-redundant byte store with voting and repair.
// Input channel in_*: one command per item; in_tuser carries the command code,
// in_tdata the address, bank, write value, default and bounds. Result channel
// out_*: exactly one result item per command.
// Every byte sits in three banks of one single-port memory; a microcoded
// sequencer makes at most one memory access per cycle, so the time per item
// follows from the accesses the command needs: a read fetches the three copies
// and votes, a repair rewrites all three copies, and a default rewrite writes
// three copies per byte. in_tready returns high together with out_tvalid once
// the result is registered.
// The output register holds a finished result while the receiver stalls; the
// sequencer waits at its finish step only if a second result is ready before
// the first is taken.
// After reset the memory is swept to the erased value, one byte a cycle,
// through all 768 bytes; in_tready stays low during the sweep. The fault
// register resets to ok with address 255.
module triple_redundant_config_store
  import trcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // addr[7:0] bank[9:8] value[25:10] default_value[41:26]
                                  // min_value[57:42] max_value[73:58], zero pad
  input  logic [2:0]  in_tuser,   // cmd[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // read_value[15:0] used_default[16] error_code[19:17]
                                  // error_address[29:20] address_fault[30], zero pad
);

  logic                  busy_r, busy_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [2:0]            cmd_r, cmd_nxt;
  logic [7:0]            addr_r, addr_nxt;
  logic [1:0]            bank_r, bank_nxt;
  logic [15:0]           val_r, val_nxt;
  logic [15:0]           dflt_r, dflt_nxt;
  logic [15:0]           min_r, min_nxt;
  logic [15:0]           max_r, max_nxt;
  logic                  afault_r, afault_nxt;
  logic [7:0]            x_r, x_nxt;
  logic [7:0]            y_r, y_nxt;
  logic [7:0]            hi_r, hi_nxt;
  logic [7:0]            lo_r, lo_nxt;
  logic                  sev_r, sev_nxt;
  logic                  used_r, used_nxt;
  logic [2:0]            werr_r, werr_nxt;
  logic [ERR_ADDR_W-1:0] weaddr_r, weaddr_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [31:0]           out_data_r, out_data_nxt;

  uword_t                uw;
  mem_req_t              mreq;
  logic [7:0]            rdata;
  logic                  st_busy;
  logic [7:0]            la;
  logic [1:0]            bidx;
  logic [7:0]            vdflt;
  vote_t                 vres;
  logic [15:0]           wv;
  logic                  rng_ok;
  logic                  keep;
  logic                  jump;
  logic [2:0]            flt_code;
  logic [ERR_ADDR_W-1:0] flt_addr;
  logic                  out_free;
  logic                  in_acc;
  logic                  in_word;
  logic                  in_known;
  logic                  in_af;
  logic [7:0]            in_addr;
  logic [1:0]            in_bank;
  logic [15:0]           rv;

  trcs_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rdata (rdata),
    .busy  (st_busy)
  );

  assign in_tready  = !busy_r && !st_busy;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;
  assign in_addr    = in_tdata[7:0];
  assign in_bank    = in_tdata[9:8];

  // address check on the incoming item
  always_comb begin
    in_word  = (in_tuser == CMD_READ_W) || (in_tuser == CMD_WRITE_W);
    in_known = (in_tuser == CMD_READ_B) || (in_tuser == CMD_WRITE_B) || in_word ||
               (in_tuser == CMD_RAW);
    in_af    = in_known && ((int'(in_addr) >= BANK_BYTES) ||
               (in_word && (int'(in_addr) + 1 >= BANK_BYTES)) ||
               ((in_tuser == CMD_RAW) && (in_bank > 2'(NUM_BANKS - 1))));
  end

  // control word decode and datapath
  always_comb begin
    uw    = ucode(step_r);
    la    = uw.hi ? addr_r + 8'd1 : addr_r;
    bidx  = (uw.bsel == BSEL_RAW) ? bank_r : uw.bsel;
    vdflt = uw.hi ? dflt_r[15:8] : dflt_r[7:0];
    vres  = vote(x_r, y_r, rdata, vdflt);
    wv    = {hi_r, lo_r};

    mreq.en   = busy_r && (uw.mop != MOP_NONE);
    mreq.we   = (uw.mop == MOP_WRITE);
    mreq.addr = phys_of(bidx, la);
    unique case (uw.wsel)
      WS_LOV:     mreq.wdata = lo_r;
      WS_HIV:     mreq.wdata = hi_r;
      WS_VAL_LO:  mreq.wdata = val_r[7:0];
      WS_VAL_HI:  mreq.wdata = val_r[15:8];
      WS_DFLT_LO: mreq.wdata = dflt_r[7:0];
      WS_DFLT_HI: mreq.wdata = dflt_r[15:8];
      default:    mreq.wdata = lo_r;
    endcase

    // range checks
    if (uw.act == ACT_RANGE_W) begin
      rng_ok = (wv >= min_r) && (wv <= max_r);
      keep   = sev_r || rng_ok;
    end else begin
      rng_ok = (lo_r >= min_r[7:0]) && (lo_r <= max_r[7:0]);
      keep   = rng_ok;
    end

    unique case (uw.jc)
      J_ALWAYS: jump = 1'b1;
      J_NOFIX:  jump = !vres.fix;
      J_KEEP:   jump = keep;
      default:  jump = 1'b0;
    endcase

    // fault candidate of this step
    flt_code = ERR_OK;
    flt_addr = ERR_ADDR_W'(phys_of(vres.bank, la));
    if (uw.act == ACT_VOTE_HI || uw.act == ACT_VOTE_LO) begin
      flt_code = vres.code;
    end else if ((uw.act == ACT_RANGE_B || uw.act == ACT_RANGE_W) && !rng_ok &&
                 !(uw.act == ACT_RANGE_W && sev_r)) begin
      flt_code = ERR_REINIT;
      flt_addr = ERR_ADDR_W'(phys_of(BSEL_0, addr_r));
    end

    // delivered read value
    if (afault_r) begin
      rv = '0;
    end else if (cmd_r == CMD_READ_B) begin
      rv = {8'h00, lo_r};
    end else if (cmd_r == CMD_READ_W) begin
      rv = wv;
    end else begin
      rv = '0;
    end
  end

  // sequencer and register updates
  always_comb begin
    busy_nxt      = busy_r;
    step_nxt      = step_r;
    cmd_nxt       = cmd_r;
    addr_nxt      = addr_r;
    bank_nxt      = bank_r;
    val_nxt       = val_r;
    dflt_nxt      = dflt_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    afault_nxt    = afault_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    sev_nxt       = sev_r;
    used_nxt      = used_r;
    werr_nxt      = werr_r;
    weaddr_nxt    = weaddr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    if (in_acc) begin
      // take a new item
      busy_nxt   = 1'b1;
      cmd_nxt    = in_tuser;
      addr_nxt   = in_addr;
      bank_nxt   = in_bank;
      val_nxt    = in_tdata[25:10];
      dflt_nxt   = in_tdata[41:26];
      min_nxt    = in_tdata[57:42];
      max_nxt    = in_tdata[73:58];
      afault_nxt = in_af;
      sev_nxt    = 1'b0;
      used_nxt   = 1'b0;
      step_nxt   = in_af ? ST_FIN : entry(in_tuser);
    end else if (busy_r) begin
      step_nxt = jump ? uw.tgt : step_r + 1'b1;

      // capture copies as they come back
      if (uw.cap == CAP_X) begin
        x_nxt = rdata;
      end
      if (uw.cap == CAP_Y) begin
        y_nxt = rdata;
      end

      unique case (uw.act)
        ACT_VOTE_HI: begin
          hi_nxt   = vres.val;
          sev_nxt  = sev_r || vres.sev;
          used_nxt = used_r || vres.sev;
        end
        ACT_VOTE_LO: begin
          lo_nxt   = vres.val;
          sev_nxt  = sev_r || vres.sev;
          used_nxt = used_r || vres.sev;
        end
        ACT_RANGE_B: begin
          if (!keep) begin
            lo_nxt   = dflt_r[7:0];
            used_nxt = 1'b1;
          end
        end
        ACT_RANGE_W: begin
          if (sev_r || !rng_ok) begin
            hi_nxt   = dflt_r[15:8];
            lo_nxt   = dflt_r[7:0];
            used_nxt = 1'b1;
          end
        end
        ACT_FIN: begin
          step_nxt = step_r;
          if (out_free) begin
            busy_nxt      = 1'b0;
            out_valid_nxt = 1'b1;
            out_data_nxt  = {1'b0, afault_r, weaddr_r, werr_r, used_r, rv};
            if (cmd_r == CMD_CLEAR) begin
              werr_nxt = ERR_OK;
            end
          end
        end
        default: begin
        end
      endcase

      // keep the worst fault
      if (flt_code > werr_r) begin
        werr_nxt   = flt_code;
        weaddr_nxt = flt_addr;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= ST_FIN;
      werr_r      <= ERR_OK;
      weaddr_r    <= ERR_ADDR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      werr_r      <= werr_nxt;
      weaddr_r    <= weaddr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    addr_r     <= addr_nxt;
    bank_r     <= bank_nxt;
    val_r      <= val_nxt;
    dflt_r     <= dflt_nxt;
    min_r      <= min_nxt;
    max_r      <= max_nxt;
    afault_r   <= afault_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    hi_r       <= hi_nxt;
    lo_r       <= lo_nxt;
    sev_r      <= sev_nxt;
    used_r     <= used_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

[tb/sv/tb_triple_redundant_config_store.sv]
`timescale 1ns / 1ps

module tb_triple_redundant_config_store;
  import trcs_pkg::*;

  localparam int N_ITEMS     = 1350;
  localparam int N_DIR       = 26;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 30;

  // command codes the block ignores
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  addr;
    logic [1:0]  bank;
    logic [15:0] value;
    logic [15:0] dflt;
    logic [15:0] lo_bound;
    logic [15:0] hi_bound;
  } cmd_item_t;

  typedef struct packed {
    logic [15:0] rv;
    logic        used;
    logic [2:0]  code;
    logic [9:0]  eaddr;
    logic        af;
  } result_t;

  typedef struct packed {
    cmd_item_t it;
    logic      typed;
    result_t   want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  // predictor state
  logic [7:0] copies [0:STORE_DEPTH-1];
  logic [2:0] worst_code;
  logic [9:0] worst_addr;

  result_t     pending_results [$];
  int          fail_cnt = 0;
  int          n_sent = 0;
  int unsigned cycles = 0;
  bit          idle_on = 1'b1;
  bit          long_hold_req = 1'b0;
  int          stall_left = 0;

  triple_redundant_config_store dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run time guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_triple_redundant_config_store failed");
      $finish;
    end
  end

  function automatic cmd_item_t cmd_fields(logic [2:0] cmd, logic [7:0] addr,
                                           logic [1:0] bank, logic [15:0] value,
                                           logic [15:0] dflt, logic [15:0] lo_bound,
                                           logic [15:0] hi_bound);
    cmd_item_t it;
    it.cmd      = cmd;
    it.addr     = addr;
    it.bank     = bank;
    it.value    = value;
    it.dflt     = dflt;
    it.lo_bound = lo_bound;
    it.hi_bound = hi_bound;
    return it;
  endfunction

  function automatic result_t res(logic [15:0] rv, logic used, logic [2:0] code,
                                  logic [9:0] eaddr, logic af);
    result_t r;
    r.rv    = rv;
    r.used  = used;
    r.code  = code;
    r.eaddr = eaddr;
    r.af    = af;
    return r;
  endfunction

  function automatic row_t row(cmd_item_t it, logic typed, result_t want);
    row_t r;
    r.it    = it;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  // fault register keeps the worst code only
  function automatic void log_fault(logic [2:0] code, int phys);
    if (code > worst_code) begin
      worst_code = code;
      worst_addr = phys[9:0];
    end
  endfunction

  function automatic void fill_all(int a, logic [7:0] v);
    copies[a]                = v;
    copies[a + BANK_BYTES]   = v;
    copies[a + 2*BANK_BYTES] = v;
  endfunction

  // vote over the three copies of one byte, repairing where possible
  function automatic logic [7:0] majority_byte(int a, logic [7:0] d, inout bit severe);
    logic [7:0] x, y, z;
    x = copies[a];
    y = copies[a + BANK_BYTES];
    z = copies[a + 2*BANK_BYTES];
    if (x == y && y == z) return x;
    // copies 1 and 2 still erased: fill from copy 0
    if (y == ERASED && z == ERASED) begin
      fill_all(a, x);
      return x;
    end
    if (x == y) begin
      log_fault(ERR_CORR, a + 2*BANK_BYTES);
      fill_all(a, x);
      return x;
    end
    if (x == z) begin
      log_fault(ERR_CORR, a + BANK_BYTES);
      fill_all(a, x);
      return x;
    end
    if (y == z) begin
      log_fault(ERR_CORR, a);
      fill_all(a, y);
      return y;
    end
    log_fault(ERR_SEVERE, a);
    severe = 1'b1;
    return d;
  endfunction

  function automatic result_t predict_store(cmd_item_t it);
    result_t     r;
    bit          word;
    bit          sev;
    logic [7:0]  v8, hi8, lo8;
    logic [15:0] w;
    int          a;
    r    = '0;
    a    = it.addr;
    sev  = 1'b0;
    word = (it.cmd == CMD_READ_W) || (it.cmd == CMD_WRITE_W);
    if (it.cmd <= CMD_RAW && it.cmd != CMD_CLEAR)
      r.af = (a >= BANK_BYTES) || (word && a + 1 >= BANK_BYTES) ||
             (it.cmd == CMD_RAW && it.bank > BSEL_2);
    if (!r.af) begin
      case (it.cmd)
        CMD_READ_B: begin
          v8 = majority_byte(a, it.dflt[7:0], sev);
          if (sev) r.used = 1'b1;
          if (v8 < it.lo_bound[7:0] || v8 > it.hi_bound[7:0]) begin
            log_fault(ERR_REINIT, a);
            v8 = it.dflt[7:0];
            fill_all(a, v8);
            r.used = 1'b1;
          end
          r.rv = {8'h00, v8};
        end
        CMD_WRITE_B: fill_all(a, it.value[7:0]);
        CMD_READ_W: begin
          // high byte is voted first
          hi8 = majority_byte(a + 1, it.dflt[15:8], sev);
          lo8 = majority_byte(a, it.dflt[7:0], sev);
          w   = {hi8, lo8};
          if (sev) begin
            w      = it.dflt;
            r.used = 1'b1;
          end else if (w < it.lo_bound || w > it.hi_bound) begin
            log_fault(ERR_REINIT, a);
            w = it.dflt;
            fill_all(a + 1, w[15:8]);
            fill_all(a, w[7:0]);
            r.used = 1'b1;
          end
          r.rv = w;
        end
        CMD_WRITE_W: begin
          fill_all(a + 1, it.value[15:8]);
          fill_all(a, it.value[7:0]);
        end
        CMD_RAW: copies[int'(it.bank) * BANK_BYTES + a] = it.value[7:0];
        default: ;
      endcase
    end
    r.code = worst_code;
    if (it.cmd == CMD_CLEAR) worst_code = ERR_OK;
    r.eaddr = worst_addr;
    return r;
  endfunction

  // data values leaning toward the erased pattern and zero
  function automatic logic [15:0] rand_val();
    case ($urandom_range(0, 7))
      0: return 16'hFFFF;
      1: return 16'h0000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic void pick_bounds(output logic [15:0] lo_b, output logic [15:0] hi_b);
    case ($urandom_range(0, 3))
      0, 1: begin
        lo_b = 16'h0000;
        hi_b = 16'hFFFF;
      end
      2: begin
        lo_b = 16'($urandom_range(0, 65535));
        hi_b = 16'($urandom_range(0, 65535));
      end
      default: begin
        lo_b = 16'($urandom_range(0, 255));
        hi_b = lo_b + 16'($urandom_range(0, 600));
      end
    endcase
  endfunction

  // offer one item, called and returning at a falling edge
  task automatic send_cmd(cmd_item_t it, logic typed, result_t want);
    result_t model_res;
    int      gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.cmd;
    in_tdata  <= {6'b0, it.hi_bound, it.lo_bound, it.dflt, it.value, it.bank, it.addr};
    do @(posedge clk); while (!in_tready);
    model_res = predict_store(it);
    pending_results.push_back(typed ? want : model_res);
    if (it.cmd <= CMD_RAW) n_sent++;
    @(negedge clk);
  endtask

  task automatic send_read(logic word, logic [7:0] a);
    logic [15:0] lo_b, hi_b;
    pick_bounds(lo_b, hi_b);
    send_cmd(cmd_fields(word ? CMD_READ_W : CMD_READ_B, a, 2'($urandom_range(0, 3)),
                        16'($urandom_range(0, 65535)), rand_val(), lo_b, hi_b),
             1'b0, '0);
  endtask

  // receiver: random stall bursts plus one long hold on request
  initial begin
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = LONG_HOLD - 1;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 11);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin : check_results
    result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = res(out_tdata[15:0], out_tdata[16], out_tdata[19:17], out_tdata[29:20],
                out_tdata[30]);
      if (pending_results.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected result item: rv=%h used=%b code=%0d eaddr=%0d af=%b",
                   got.rv, got.used, got.code, got.eaddr, got.af);
      end else begin
        want = pending_results.pop_front();
        if (got.rv !== want.rv || got.used !== want.used || got.code !== want.code ||
            got.eaddr !== want.eaddr || got.af !== want.af) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("mismatch at cycle %0d: exp rv=%h used=%b code=%0d eaddr=%0d af=%b",
                     cycles, want.rv, want.used, want.code, want.eaddr, want.af);
            $display("  got rv=%h used=%b code=%0d eaddr=%0d af=%b",
                     got.rv, got.used, got.code, got.eaddr, got.af);
          end
        end
      end
    end
  end

  initial begin
    row_t        dir_tbl [0:N_DIR-1];
    logic        word;
    logic [7:0]  a;
    int          nraw;
    bit          did_hold;
    bit          did_drain;

    for (int i = 0; i < STORE_DEPTH; i++) copies[i] = ERASED;
    worst_code = ERR_OK;
    worst_addr = ERR_ADDR_RESET;
    did_hold   = 1'b0;
    did_drain  = 1'b0;

    // directed items: erased reads, bad spans, ignored codes, each vote outcome
    dir_tbl = '{
      row(cmd_fields(CMD_READ_B, 8'd255, 2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h00FF),
          1'b1, res(16'h00FF, 1'b0, ERR_OK, ERR_ADDR_RESET, 1'b0)),
      row(cmd_fields(CMD_READ_W, 8'd254, 2'd0, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF),
          1'b1, res(16'hFFFF, 1'b0, ERR_OK, ERR_ADDR_RESET, 1'b0)),
      row(cmd_fields(CMD_WRITE_W, 8'd255, 2'd0, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF),
          1'b1, res(16'h0000, 1'b0, ERR_OK, ERR_ADDR_RESET, 1'b1)),
      row(cmd_fields(CMD_READ_W, 8'd255, 2'd0, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF),
          1'b1, res(16'h0000, 1'b0, ERR_OK, ERR_ADDR_RESET, 1'b1)),
      row(cmd_fields(CMD_RAW, 8'd10, 2'd3, 16'h00A5, 16'h0000, 16'h0000, 16'hFFFF),
          1'b1, res(16'h0000, 1'b0, ERR_OK, ERR_ADDR_RESET, 1'b1)),
      row(cmd_fields(CMD_SPARE_6, 8'd255, 2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
          1'b1, res(16'h0000, 1'b0, ERR_OK, ERR_ADDR_RESET, 1'b0)),
      row(cmd_fields(CMD_SPARE_7, 8'd0, 2'd0, 16'h1234, 16'h5678, 16'h0000, 16'h0000),
          1'b1, res(16'h0000, 1'b0, ERR_OK, ERR_ADDR_RESET, 1'b0)),
      // bank 2 odd copy
      row(cmd_fields(CMD_WRITE_B, 8'd2, 2'd0, 16'h12AA, 16'h0, 16'h0, 16'hFFFF), 1'b0, '0),
      row(cmd_fields(CMD_RAW, 8'd2, 2'd2, 16'h0000, 16'h0, 16'h0, 16'hFFFF), 1'b0, '0),
      row(cmd_fields(CMD_READ_B, 8'd2, 2'd0, 16'h0000, 16'h0, 16'h0, 16'h00FF), 1'b0, '0),
      row(cmd_fields(CMD_CLEAR, 8'd0, 2'd0, 16'h0000, 16'h0, 16'h0, 16'h0000), 1'b0, '0),
      // bank 1 odd copy
      row(cmd_fields(CMD_WRITE_B, 8'd3, 2'd0, 16'h0011, 16'h0, 16'h0, 16'hFFFF), 1'b0, '0),
      row(cmd_fields(CMD_RAW, 8'd3, 2'd1, 16'h0022, 16'h0, 16'h0, 16'hFFFF), 1'b0, '0),
      row(cmd_fields(CMD_READ_B, 8'd3, 2'd0, 16'h0000, 16'h0, 16'h0, 16'h00FF), 1'b0, '0),
      row(cmd_fields(CMD_CLEAR, 8'd0, 2'd0, 16'h0000, 16'h0, 16'h0, 16'h0000), 1'b0, '0),
      // copies 1 and 2 erased: fill without fault
      row(cmd_fields(CMD_RAW, 8'd4, 2'd0, 16'h0033, 16'h0, 16'h0, 16'hFFFF), 1'b0, '0),
      row(cmd_fields(CMD_READ_B, 8'd4, 2'd0, 16'h0000, 16'h0, 16'h0, 16'h00FF), 1'b0, '0),
      // bank 0 odd copy
      row(cmd_fields(CMD_WRITE_B, 8'd5, 2'd0, 16'h0077, 16'h0, 16'h0, 16'hFFFF), 1'b0, '0),
      row(cmd_fields(CMD_RAW, 8'd5, 2'd0, 16'h0066, 16'h0, 16'h0, 16'hFFFF), 1'b0, '0),
      row(cmd_fields(CMD_READ_B, 8'd5, 2'd0, 16'h0000, 16'h0, 16'h0, 16'h00FF), 1'b0, '0),
      // three different copies in the high byte of a word
      row(cmd_fields(CMD_RAW, 8'd5, 2'd1, 16'h0001, 16'h0, 16'h0, 16'hFFFF), 1'b0, '0),
      row(cmd_fields(CMD_RAW, 8'd5, 2'd2, 16'h0002, 16'h0, 16'h0, 16'hFFFF), 1'b0, '0),
      row(cmd_fields(CMD_READ_W, 8'd4, 2'd0, 16'h0000, 16'hBEEF, 16'h0, 16'hFFFF),
          1'b0, '0),
      row(cmd_fields(CMD_CLEAR, 8'd0, 2'd0, 16'h0000, 16'h0, 16'h0, 16'h0000), 1'b0, '0),
      // out of range byte and word
      row(cmd_fields(CMD_READ_B, 8'd4, 2'd0, 16'h0000, 16'h0000, 16'h0040, 16'h00FF),
          1'b0, '0),
      row(cmd_fields(CMD_READ_W, 8'd2, 2'd0, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF),
          1'b0, '0)
    };

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_DIR; i++) send_cmd(dir_tbl[i].it, dir_tbl[i].typed, dir_tbl[i].want);

    // random part: mostly write, inject, read sequences on one address
    while (n_sent < N_ITEMS) begin
      idle_on = (n_sent < N_ITEMS - 150) && ((n_sent / 128) % 4 != 3);
      if (!did_hold && n_sent > 400) begin
        long_hold_req = 1'b1;
        did_hold      = 1'b1;
      end
      if (!did_drain && n_sent > 800) begin
        did_drain = 1'b1;
        in_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
      end
      case ($urandom_range(0, 15))
        12, 13: begin
          send_cmd(cmd_fields(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                              2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                              16'($urandom_range(0, 65535))), 1'b0, '0);
        end
        14: begin
          send_cmd(cmd_fields(CMD_CLEAR, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                              rand_val(), rand_val(), rand_val(), rand_val()), 1'b0, '0);
        end
        15: begin
          case ($urandom_range(0, 2))
            0: send_cmd(cmd_fields(CMD_WRITE_W, 8'd255, 2'($urandom_range(0, 3)), rand_val(),
                                   rand_val(), rand_val(), rand_val()), 1'b0, '0);
            1: send_read(1'b1, 8'd255);
            default: send_cmd(cmd_fields(CMD_RAW, 8'($urandom_range(0, 255)), 2'd3,
                                         rand_val(), rand_val(), rand_val(), rand_val()),
                              1'b0, '0);
          endcase
        end
        default: begin
          word = 1'($urandom_range(0, 1));
          if ($urandom_range(0, 7) == 0) a = word ? 8'd254 : 8'd255;
          else a = word ? 8'($urandom_range(0, 254)) : 8'($urandom_range(0, 255));
          if ($urandom_range(0, 3) != 0)
            send_cmd(cmd_fields(word ? CMD_WRITE_W : CMD_WRITE_B, a,
                                2'($urandom_range(0, 3)), rand_val(), rand_val(),
                                rand_val(), rand_val()), 1'b0, '0);
          nraw = $urandom_range(0, 3);
          repeat (nraw)
            send_cmd(cmd_fields(CMD_RAW, a + 8'(word ? $urandom_range(0, 1) : 0),
                                2'($urandom_range(0, 2)), rand_val(), rand_val(),
                                rand_val(), rand_val()), 1'b0, '0);
          send_read(word, a);
          if ($urandom_range(0, 1) == 0) send_read(word, a);
        end
      endcase
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    if (fail_cnt == 0 && pending_results.size() == 0)
      $display("tb_triple_redundant_config_store passed");
    else
      $display("tb_triple_redundant_config_store failed");
    $finish;
  end

endmodule
